// ===== sv/assert_macros.svh =====
// assertion macros shared by the raycaster rtl
// no dependencies; compiled out when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define GRC_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define GRC_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define GRC_ASSERT(lbl, clk, rst, prop, msg)
`define GRC_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

// ===== sv/grc_pkg.sv =====
// shared constants, types and the shade table of the column raycaster
// no dependencies
package grc_pkg;

  localparam int MAP_SIZE      = 16;
  localparam int SCREEN_WIDTH  = 80;
  localparam int SCREEN_HEIGHT = 24;
  localparam int SHADE_LEVELS  = 16;
  localparam int MAX_STEPS     = 2 * MAP_SIZE + 2;

  localparam int MAP_DEPTH = 256;
  localparam int MAP_AW    = 8;

  // operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_CAST = 1'b1;

  localparam logic [7:0] CHAR_EMPTY = 8'h20;
  localparam logic [7:0] CHAR_EDGE  = 8'h30;

  // ray components and grid distances
  localparam int RAY_W  = 25;
  localparam int MAG_W  = 24;
  localparam int DIST_W = 14;
  localparam int PROD_W = DIST_W + MAG_W;
  localparam int POS_W  = 7;
  localparam int STEP_W = 6;

  // height = H*256*a / (p*W*2^14), reduced by 2048
  localparam int H_NUM = SCREEN_HEIGHT * 256 / 2048;
  localparam int H_DEN = SCREEN_WIDTH * 16384 / 2048;
  // shade quotient = p*W*2^14 / (64*a)
  localparam int Q_NUM = SCREEN_WIDTH * 256;

  // divider sizes
  localparam int NUM_W  = 28;
  localparam int DEN_W  = 24;
  localparam int DIV_QW = 7;
  localparam int CNT_W  = 3;
  localparam int HGT_W  = 6;
  localparam int SID_W  = 4;

  typedef struct packed {
    logic              done;
    logic              sat;
    logic [DIV_QW-1:0] quot;
  } div_res_t;

  // shade characters, nearest first
  function automatic logic [7:0] shade_char_f(input logic [SID_W-1:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h26; // &
      4'd1:    c = 8'h23; // #
      4'd2:    c = 8'h57; // W
      4'd3:    c = 8'h40; // @
      4'd4:    c = 8'h4B; // K
      4'd5:    c = 8'h4F; // O
      4'd6:    c = 8'h4A; // J
      4'd7:    c = 8'h6F; // o
      4'd8:    c = 8'h73; // s
      4'd9:    c = 8'h3F; // ?
      4'd10:   c = 8'h2B; // +
      4'd11:   c = 8'h5E; // ^
      4'd12:   c = 8'h27; // '
      4'd13:   c = 8'h3A; // :
      4'd14:   c = 8'h2E; // .
      default: c = 8'h20; // space
    endcase
    return c;
  endfunction

endpackage

// ===== sv/grc_if.sv =====
// valid/ready channel interfaces for load and cast commands and column results
// depends on nothing
interface grc_in_if;
  logic              valid;
  logic              ready;
  logic              operation;
  logic [7:0]        cell_index;
  logic [7:0]        cell_value;
  logic [6:0]        column;
  logic [11:0]       cam_x;
  logic [11:0]       cam_y;
  logic signed [15:0] dir_x;
  logic signed [15:0] dir_y;
  logic signed [15:0] plane_x;
  logic signed [15:0] plane_y;
  modport source (output valid, operation, cell_index, cell_value, column,
                  cam_x, cam_y, dir_x, dir_y, plane_x, plane_y, input ready);
  modport sink (input valid, operation, cell_index, cell_value, column,
                cam_x, cam_y, dir_x, dir_y, plane_x, plane_y, output ready);
endinterface

interface grc_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] out_column;
  logic [4:0] span_start;
  logic [4:0] span_end;
  logic [7:0] shade_char;
  logic [3:0] wall_colour;
  logic       hit_edge;
  modport source (output valid, out_column, span_start, span_end, shade_char,
                  wall_colour, hit_edge, input ready);
  modport sink (input valid, out_column, span_start, span_end, shade_char,
                wall_colour, hit_edge, output ready);
endinterface

// ===== sv/grc_ram.sv =====
// generic single write, single read ram with registered read data
// no dependencies
module grc_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
  end

  // read port, registered read data
  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

// ===== sv/grc_div.sv =====
// restoring divider, one quotient bit a cycle, saturating quotient
// depends on grc_pkg
module grc_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [grc_pkg::NUM_W-1:0] num,
  input  logic [grc_pkg::DEN_W-1:0] den,
  output grc_pkg::div_res_t         res
);

  localparam int SH_W = grc_pkg::DEN_W + grc_pkg::DIV_QW;

  logic [grc_pkg::NUM_W-1:0]  rem;
  logic [SH_W-2:0]            dsh;
  logic [grc_pkg::DIV_QW-1:0] quot;
  logic [grc_pkg::CNT_W-1:0]  cnt;
  logic                       busy;
  logic                       sat;
  logic                       done;
  logic                       fits;

  // trial subtract of the shifted divisor
  assign fits = (SH_W'(rem) >= SH_W'(dsh));

  // iteration control and datapath
  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (start) begin
      rem  <= num;
      dsh  <= {den, (grc_pkg::DIV_QW-1)'(0)};
      sat  <= (SH_W'(num) >= SH_W'({den, grc_pkg::DIV_QW'(0)}));
      quot <= '0;
      cnt  <= grc_pkg::CNT_W'(grc_pkg::DIV_QW);
      busy <= 1'b1;
    end else if (busy) begin
      if (fits) begin
        rem  <= rem - grc_pkg::NUM_W'(dsh);
        quot <= {quot[grc_pkg::DIV_QW-2:0], 1'b1};
      end else begin
        quot <= {quot[grc_pkg::DIV_QW-2:0], 1'b0};
      end
      dsh <= dsh >> 1;
      cnt <= cnt - 1'b1;
      if (cnt == grc_pkg::CNT_W'(1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end
  end

  assign res.done = done;
  assign res.sat  = sat;
  assign res.quot = quot;

endmodule

// ===== sv/grc_top.sv =====
// column raycaster top level: command decode, grid walk and span shading
// depends on grc_pkg, grc_if, grc_ram, grc_div and assert_macros.svh
`include "assert_macros.svh"

// A load word writes one map cell. A cast word runs a grid walk over the map
// memory: the setup states (S_SETUP, S_INIT, S_MUL), then for each grid step
// a step decision and, unless the step leaves the map, a check of the
// registered map read, for at most 34 grid steps; then the height and
// shade divisions when the crossed ray component and the distance are both
// nonzero, a direct assignment otherwise, and a finish state. The two serial
// dividers and the registered map read set how long a cast takes. One cast is in work at
// a time; a finished result waits in the output register while the next word
// is taken. Map cells that were never loaded read as undefined.
module grid_raycast_column (
  input logic       clk,
  input logic       rst,
  grc_in_if.sink    cast_in,
  grc_out_if.source res_out
);

  typedef enum logic [3:0] {
    S_IDLE, S_SETUP, S_INIT, S_MUL, S_DEC, S_CHK, S_DIV, S_DIVW, S_FIN
  } state_t;

  state_t state;

  // captured cast word
  logic [6:0]         col;
  logic [11:0]        cx, cy;
  logic signed [15:0] dirx, diry, plx, ply;

  // walk state
  logic signed [grc_pkg::RAY_W-1:0] rx, ry;
  logic [grc_pkg::MAG_W-1:0]        ax, ay;
  logic                             negx, negy;
  logic [grc_pkg::DIST_W-1:0]       dx, dy, perp;
  logic [grc_pkg::PROD_W-1:0]       px, py;
  logic signed [grc_pkg::POS_W-1:0] mx, my;
  logic [grc_pkg::STEP_W-1:0]       step;
  logic                             side, edge_hit;
  logic [7:0]                       wall;
  logic [grc_pkg::HGT_W-1:0]        hgt;
  logic [grc_pkg::SID_W-1:0]        sid;

  // output register
  logic       ov;
  logic [6:0] o_col;
  logic [4:0] o_start, o_end;
  logic [7:0] o_char;
  logic [3:0] o_colour;
  logic       o_edge;

  logic [7:0] rdata;

  // ray direction from column offset
  logic signed [8:0]                off;
  logic signed [grc_pkg::RAY_W-1:0] off_e, w_e, rx_c, ry_c;

  assign off   = $signed({1'b0, col, 1'b0}) - 9'(grc_pkg::SCREEN_WIDTH);
  assign off_e = grc_pkg::RAY_W'(off);
  assign w_e   = grc_pkg::RAY_W'(grc_pkg::SCREEN_WIDTH);
  assign rx_c  = grc_pkg::RAY_W'(dirx) * w_e + grc_pkg::RAY_W'(plx) * off_e;
  assign ry_c  = grc_pkg::RAY_W'(diry) * w_e + grc_pkg::RAY_W'(ply) * off_e;

  // step decision and next cell
  logic                             take_x, outside;
  logic signed [grc_pkg::POS_W-1:0] mx_n, my_n;
  logic [grc_pkg::MAP_AW-1:0]       raddr;

  assign take_x = (ax != '0) && ((ay == '0) || (px < py));
  always_comb begin
    mx_n = mx;
    my_n = my;
    if (take_x) mx_n = negx ? mx - grc_pkg::POS_W'(1) : mx + grc_pkg::POS_W'(1);
    else        my_n = negy ? my - grc_pkg::POS_W'(1) : my + grc_pkg::POS_W'(1);
  end
  assign outside = (mx_n < 0) || (my_n < 0) ||
                   (mx_n >= grc_pkg::POS_W'(grc_pkg::MAP_SIZE)) ||
                   (my_n >= grc_pkg::POS_W'(grc_pkg::MAP_SIZE));
  assign raddr = grc_pkg::MAP_AW'(int'(mx_n) + int'(my_n) * grc_pkg::MAP_SIZE);

  // map memory
  logic load_we, map_re;
  assign cast_in.ready = (state == S_IDLE);
  assign load_we = cast_in.valid && cast_in.ready && (cast_in.operation == grc_pkg::OP_LOAD);
  assign map_re  = (state == S_DEC) && !outside;

  grc_ram #(.DEPTH(grc_pkg::MAP_DEPTH), .WIDTH(8)) u_map (
    .clk   (clk),
    .we    (load_we),
    .waddr (cast_in.cell_index),
    .wdata (cast_in.cell_value),
    .re    (map_re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // height and shade dividers
  logic [grc_pkg::MAG_W-1:0] a_sel;
  logic                      div_go;
  grc_pkg::div_res_t         hres, qres;

  assign a_sel  = side ? ay : ax;
  assign div_go = (state == S_DIV) && (a_sel != '0) && (perp != '0);

  grc_div u_hdiv (
    .clk   (clk),
    .rst   (rst),
    .start (div_go),
    .num   (grc_pkg::NUM_W'(a_sel) * grc_pkg::NUM_W'(grc_pkg::H_NUM)),
    .den   (grc_pkg::DEN_W'(perp) * grc_pkg::DEN_W'(grc_pkg::H_DEN)),
    .res   (hres)
  );

  grc_div u_qdiv (
    .clk   (clk),
    .rst   (rst),
    .start (div_go),
    .num   (grc_pkg::NUM_W'(perp) * grc_pkg::NUM_W'(grc_pkg::Q_NUM)),
    .den   (a_sel),
    .res   (qres)
  );

  function automatic logic [grc_pkg::DIV_QW-1:0] DIV_QW_H(input int v);
    return grc_pkg::DIV_QW'(v);
  endfunction

  // clamp of division results
  logic [grc_pkg::HGT_W-1:0] hgt_c;
  logic [grc_pkg::SID_W-1:0] sid_c;
  always_comb begin
    if (hres.sat || hres.quot > DIV_QW_H(2 * grc_pkg::SCREEN_HEIGHT))
      hgt_c = grc_pkg::HGT_W'(2 * grc_pkg::SCREEN_HEIGHT);
    else
      hgt_c = grc_pkg::HGT_W'(hres.quot);
    if (qres.sat || qres.quot > DIV_QW_H(grc_pkg::SHADE_LEVELS))
      sid_c = grc_pkg::SID_W'(grc_pkg::SHADE_LEVELS - 1);
    else if (qres.quot < DIV_QW_H(2))
      sid_c = '0;
    else
      sid_c = grc_pkg::SID_W'(qres.quot - DIV_QW_H(2));
  end

  // span and character of the finished column
  logic [4:0] half, s_start, s_end;
  localparam logic [4:0] MID  = 5'(grc_pkg::SCREEN_HEIGHT / 2);
  localparam logic [4:0] LAST = 5'(grc_pkg::SCREEN_HEIGHT - 1);
  assign half    = hgt[grc_pkg::HGT_W-1:1];
  assign s_start = (half >= MID) ? 5'd0 : MID - half;
  assign s_end   = (6'(half) + 6'(MID) >= 6'(LAST)) ? LAST : half + MID;

  // sequencer
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (cast_in.valid && cast_in.operation == grc_pkg::OP_CAST) begin
          col   <= cast_in.column;
          cx    <= cast_in.cam_x;
          cy    <= cast_in.cam_y;
          dirx  <= cast_in.dir_x;
          diry  <= cast_in.dir_y;
          plx   <= cast_in.plane_x;
          ply   <= cast_in.plane_y;
          state <= S_SETUP;
        end
      end
      S_SETUP: begin
        rx    <= rx_c;
        ry    <= ry_c;
        state <= S_INIT;
      end
      S_INIT: begin
        ax    <= grc_pkg::MAG_W'(rx[grc_pkg::RAY_W-1] ? -rx : rx);
        ay    <= grc_pkg::MAG_W'(ry[grc_pkg::RAY_W-1] ? -ry : ry);
        negx  <= rx[grc_pkg::RAY_W-1];
        negy  <= ry[grc_pkg::RAY_W-1];
        dx    <= rx[grc_pkg::RAY_W-1] ? grc_pkg::DIST_W'(cx[7:0])
                                      : grc_pkg::DIST_W'(256) - grc_pkg::DIST_W'(cx[7:0]);
        dy    <= ry[grc_pkg::RAY_W-1] ? grc_pkg::DIST_W'(cy[7:0])
                                      : grc_pkg::DIST_W'(256) - grc_pkg::DIST_W'(cy[7:0]);
        mx    <= grc_pkg::POS_W'(cx[11:8]);
        my    <= grc_pkg::POS_W'(cy[11:8]);
        step  <= '0;
        state <= S_MUL;
      end
      S_MUL: begin
        px    <= grc_pkg::PROD_W'(dx) * grc_pkg::PROD_W'(ay);
        py    <= grc_pkg::PROD_W'(dy) * grc_pkg::PROD_W'(ax);
        state <= S_DEC;
      end
      S_DEC: begin
        if (take_x) begin
          perp <= dx;
          dx   <= dx + grc_pkg::DIST_W'(256);
          side <= 1'b0;
        end else begin
          perp <= dy;
          dy   <= dy + grc_pkg::DIST_W'(256);
          side <= 1'b1;
        end
        mx   <= mx_n;
        my   <= my_n;
        step <= step + 1'b1;
        if (outside) begin
          edge_hit <= 1'b1;
          state    <= S_DIV;
        end else begin
          state <= S_CHK;
        end
      end
      S_CHK: begin
        if (rdata != grc_pkg::CHAR_EMPTY) begin
          wall     <= rdata;
          edge_hit <= 1'b0;
          state    <= S_DIV;
        end else if (step == grc_pkg::STEP_W'(grc_pkg::MAX_STEPS)) begin
          edge_hit <= 1'b1;
          state    <= S_DIV;
        end else begin
          px    <= grc_pkg::PROD_W'(dx) * grc_pkg::PROD_W'(ay);
          py    <= grc_pkg::PROD_W'(dy) * grc_pkg::PROD_W'(ax);
          state <= S_DEC;
        end
      end
      S_DIV: begin
        if (a_sel == '0) begin
          hgt   <= '0;
          sid   <= grc_pkg::SID_W'(grc_pkg::SHADE_LEVELS - 1);
          state <= S_FIN;
        end else if (perp == '0) begin
          hgt   <= grc_pkg::HGT_W'(grc_pkg::SCREEN_HEIGHT);
          sid   <= '0;
          state <= S_FIN;
        end else begin
          state <= S_DIVW;
        end
      end
      S_DIVW: begin
        if (hres.done) begin
          hgt   <= hgt_c;
          sid   <= sid_c;
          state <= S_FIN;
        end
      end
      S_FIN: begin
        if (!ov || res_out.ready) state <= S_IDLE;
      end
      default: state <= S_IDLE;
    endcase
    if (rst) state <= S_IDLE;
  end

  // result word register
  always_ff @(posedge clk) begin
    if (state == S_FIN && (!ov || res_out.ready)) begin
      ov       <= 1'b1;
      o_col    <= col;
      o_start  <= s_start;
      o_end    <= s_end;
      o_char   <= edge_hit ? grc_pkg::CHAR_EDGE : grc_pkg::shade_char_f(sid);
      // subtracting the space code leaves the low nibble unchanged
      o_colour <= edge_hit ? 4'd0 : wall[3:0];
      o_edge   <= edge_hit;
    end else if (res_out.ready) begin
      ov <= 1'b0;
    end
    if (rst) ov <= 1'b0;
  end

  assign res_out.valid       = ov;
  assign res_out.out_column  = o_col;
  assign res_out.span_start  = o_start;
  assign res_out.span_end    = o_end;
  assign res_out.shade_char  = o_char;
  assign res_out.wall_colour = o_colour;
  assign res_out.hit_edge    = o_edge;

  // checks
  `GRC_ASSERT(a_chk_after_dec, clk, rst, state == S_CHK |-> $past(state) == S_DEC,
              "map check without a preceding step")
  `GRC_NEVER(a_div_skew, clk, rst, hres.done != qres.done, "dividers out of step")
  `GRC_NEVER(a_step_bound, clk, rst, step > grc_pkg::STEP_W'(grc_pkg::MAX_STEPS),
             "walk ran past its step limit")
  `GRC_ASSERT(a_result_src, clk, rst, $rose(ov) |-> $past(state) == S_FIN,
              "result word loaded outside finish")

endmodule
